// ----- rtl/sphd_pkg.sv -----
// ----------------------------------------------------------------------------
// sphd_pkg
// Shared types and constants for the SPH density accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package sphd_pkg;

  localparam int unsigned COORD_FRAC_BITS_DEF = 8;
  localparam int unsigned COORD_INT_BITS_DEF  = 11;
  localparam int unsigned INV_W               = 48;
  localparam int unsigned DENS_W              = 32;
  localparam int unsigned REG_RADIUS          = 0;
  localparam int unsigned REG_INV_VOLUME      = 1;
  localparam logic [DENS_W-1:0] DENS_MAX      = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/sphd_front.sv -----
// ----------------------------------------------------------------------------
// sphd_front
// Accepts requests, forms the squared distance and the in-radius test, and
// queues the classified work for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sphd_front
  import sphd_pkg::*;
#(
  parameter int unsigned COORD_W = COORD_FRAC_BITS_DEF + COORD_INT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [COORD_W-1:0]   query_x,
  input  wire logic [COORD_W-1:0]   query_y,
  input  wire logic [COORD_W-1:0]   neighbor_x,
  input  wire logic [COORD_W-1:0]   neighbor_y,
  input  wire logic                 neighbor_present,
  input  wire logic                 last,
  input  wire logic [COORD_W-1:0]   radius,
  output logic                      q_valid,
  input  wire logic                 q_take,
  output logic [2*COORD_W:0]        q_d2,
  output logic                      q_inside,
  output logic                      q_last
);

  localparam int unsigned D2_W = 2*COORD_W + 1;

  // Stage 1: absolute differences registered.
  logic               s1_valid_r, s1_valid_nxt;
  logic [COORD_W-1:0] dx_r, dy_r, rad_r;
  logic               pres_r, last1_r;
  // Two-entry queue toward the back end.
  logic [D2_W-1:0]    qd2_r [2];
  logic               qin_r [2];
  logic               qlast_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;

  logic [D2_W-1:0]    d2;
  logic [D2_W-1:0]    r2;
  logic               s1_move;

  // Stage 1 may move into the queue when a slot is free.
  assign s1_move      = s1_valid_r && (cnt_r != 2'd2);
  assign full         = s1_valid_r && !s1_move;
  assign s1_valid_nxt = (push && !full) || (s1_valid_r && !s1_move);

  assign d2 = D2_W'(dx_r * dx_r) + D2_W'(dy_r * dy_r);
  assign r2 = D2_W'(rad_r * rad_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wp_r       <= 1'b0;
      rp_r       <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_move) wp_r <= ~wp_r;
      if (q_take && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, s1_move} - {1'b0, q_take && q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      dx_r    <= (query_x >= neighbor_x) ? query_x - neighbor_x : neighbor_x - query_x;
      dy_r    <= (query_y >= neighbor_y) ? query_y - neighbor_y : neighbor_y - query_y;
      rad_r   <= radius;
      pres_r  <= neighbor_present;
      last1_r <= last;
    end
    if (s1_move) begin
      qd2_r[wp_r]   <= d2;
      qin_r[wp_r]   <= pres_r && (d2 < r2);
      qlast_r[wp_r] <= last1_r;
    end
  end

  assign q_valid  = (cnt_r != 2'd0);
  assign q_d2     = qd2_r[rp_r];
  assign q_inside = qin_r[rp_r];
  assign q_last   = qlast_r[rp_r];

endmodule
`default_nettype wire

// ----- rtl/sphd_back.sv -----
// ----------------------------------------------------------------------------
// sphd_back
// Iterative square root, cube and scale over a shared 16x19 multiplier with
// 16-bit operand chunks, saturating accumulation and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module sphd_back
  import sphd_pkg::*;
#(
  parameter int unsigned COORD_W   = COORD_FRAC_BITS_DEF + COORD_INT_BITS_DEF,
  parameter int unsigned FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  output logic                      q_take,
  input  wire logic [2*COORD_W:0]   q_d2,
  input  wire logic                 q_inside,
  input  wire logic                 q_last,
  input  wire logic [COORD_W-1:0]   radius,
  input  wire logic [INV_W-1:0]     inv_volume,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [DENS_W-1:0]         density,
  output logic                      saturated
);

  localparam int unsigned D2_W   = 2*COORD_W + 1;
  localparam int unsigned SQ_ST  = (D2_W + 1) / 2;
  localparam int unsigned SQ_CW  = $clog2(SQ_ST + 1);
  localparam int unsigned PROD_W = 3*COORD_W + INV_W;
  localparam int unsigned SHIFT  = 3*FRAC_BITS + 24;
  localparam int unsigned PCH    = 16;
  localparam int unsigned NCH    = (PROD_W + PCH - 1) / PCH;
  localparam int unsigned MC_W   = $clog2(NCH + 1);
  localparam int unsigned OPW    = NCH * PCH;

  back_state_t state_r, state_nxt;

  logic [2*SQ_ST-1:0] rem_r, rem_nxt;
  logic [SQ_ST+1:0]   part_r, part_nxt;
  logic [SQ_ST-1:0]   root_r, root_nxt;
  logic [SQ_CW-1:0]   sq_cnt_r, sq_cnt_nxt;
  logic [1:0]         pass_r, pass_nxt;
  logic [MC_W-1:0]    ch_r, ch_nxt;
  logic [COORD_W-1:0] diff_r, diff_nxt;
  logic [OPW-1:0]     acc_r, acc_nxt;
  logic [OPW-1:0]     prod_r, prod_nxt;
  logic               last_r, last_nxt;
  logic               inside_r, inside_nxt;
  logic [DENS_W-1:0]  sum_r, sum_nxt;
  logic               ovf_r, ovf_nxt;
  logic               full_r, full_nxt;
  logic [DENS_W-1:0]  dens_r, dens_nxt;
  logic               sat_r, sat_nxt;

  logic [SQ_ST+1:0]   trial;
  logic [SQ_ST+3:0]   cand;
  logic [PCH-1:0]     chunk;
  logic [PCH+COORD_W-1:0] pp;
  logic [OPW-1:0]     term_full;
  logic               term_hi;
  logic [DENS_W-1:0]  term;
  logic [DENS_W:0]    sum_ext;

  // One bit of the root per cycle: the partial remainder takes the next two
  // bits of d2 and is compared with 4*root+1.
  assign cand    = {part_r, rem_r[2*SQ_ST-1 -: 2]};
  assign trial   = {root_r, 2'b01};
  assign chunk   = acc_r[ch_r[MC_W-1:0]*PCH +: PCH];
  assign pp      = chunk * diff_r;
  assign term_full = prod_r >> SHIFT;
  assign term_hi   = |(term_full[OPW-1:DENS_W]);
  assign term      = term_hi ? DENS_MAX : term_full[DENS_W-1:0];
  assign sum_ext   = {1'b0, sum_r} + {1'b0, term};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r   <= '0;
      ovf_r   <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      ovf_r   <= ovf_nxt;
      full_r  <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    part_r   <= part_nxt;
    root_r   <= root_nxt;
    sq_cnt_r <= sq_cnt_nxt;
    pass_r   <= pass_nxt;
    ch_r     <= ch_nxt;
    diff_r   <= diff_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    last_r   <= last_nxt;
    inside_r <= inside_nxt;
    dens_r   <= dens_nxt;
    sat_r    <= sat_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    rem_nxt    = rem_r;
    part_nxt   = part_r;
    root_nxt   = root_r;
    sq_cnt_nxt = sq_cnt_r;
    pass_nxt   = pass_r;
    ch_nxt     = ch_r;
    diff_nxt   = diff_r;
    acc_nxt    = acc_r;
    prod_nxt   = prod_r;
    last_nxt   = last_r;
    inside_nxt = inside_r;
    sum_nxt    = sum_r;
    ovf_nxt    = ovf_r;
    full_nxt   = full_r;
    dens_nxt   = dens_r;
    sat_nxt    = sat_r;
    q_take     = 1'b0;
    if (pop && full_r) full_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_take     = 1'b1;
          last_nxt   = q_last;
          inside_nxt = q_inside;
          rem_nxt    = (2*SQ_ST)'(q_d2);
          part_nxt   = '0;
          root_nxt   = '0;
          sq_cnt_nxt = '0;
          state_nxt  = q_inside ? ST_SQRT : ST_ACC;
        end
      end
      ST_SQRT: begin
        // rem_r holds the d2 bits not yet consumed, top pair first.
        rem_nxt = {rem_r[2*SQ_ST-3:0], 2'b00};
        if (cand >= (SQ_ST+4)'(trial)) begin
          part_nxt = (SQ_ST+2)'(cand - (SQ_ST+4)'(trial));
          root_nxt = {root_r[SQ_ST-2:0], 1'b1};
        end else begin
          part_nxt = (SQ_ST+2)'(cand);
          root_nxt = {root_r[SQ_ST-2:0], 1'b0};
        end
        sq_cnt_nxt = sq_cnt_r + 1'b1;
        if (sq_cnt_r == SQ_CW'(SQ_ST - 1)) begin
          state_nxt = ST_MUL;
          pass_nxt  = '0;
          ch_nxt    = '0;
          prod_nxt  = '0;
          acc_nxt   = OPW'(inv_volume);
          diff_nxt  = radius - COORD_W'(root_nxt);
        end
      end
      ST_MUL: begin
        // Three passes of acc * diff, 16 bits of acc per cycle.
        prod_nxt = prod_r + (OPW'(pp) << (ch_r * PCH));
        ch_nxt   = ch_r + 1'b1;
        if (ch_r == MC_W'(NCH - 1)) begin
          ch_nxt   = '0;
          acc_nxt  = prod_nxt;
          prod_nxt = '0;
          pass_nxt = pass_r + 1'b1;
          if (pass_r == 2'd2) begin
            prod_nxt  = prod_r + (OPW'(pp) << (ch_r * PCH));
            state_nxt = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        if (inside_r) begin
          sum_nxt = sum_ext[DENS_W] ? DENS_MAX : sum_ext[DENS_W-1:0];
          if (term_hi || sum_ext[DENS_W]) ovf_nxt = 1'b1;
        end
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!full_r || pop) begin
          dens_nxt  = sum_r;
          sat_nxt   = ovf_r;
          full_nxt  = 1'b1;
          sum_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign empty     = !full_r;
  assign density   = dens_r;
  assign saturated = sat_r;

endmodule
`default_nettype wire

// ----- rtl/sph_density_accumulator.sv -----
// ----------------------------------------------------------------------------
// sph_density_accumulator
// SPH spiky-kernel density sum over a run of neighbors of one query point.
// ----------------------------------------------------------------------------
//  channel  ports                      handshake
//  input    in_query_*, in_neighbor_*  push / full
//  result   out_density, out_saturated empty / pop
//  config   p*                         APB read and write, pready always high
//
// A neighbor inside the radius passes through the back end in order: it leaves
// the queue, takes 20 root steps, then three multiply passes of seven 16-bit
// chunks of the operand against the radius difference, and one add step.
// Other items go straight from the queue to the add; the item that closes a run then passes through the emit state.
// Reset is synchronous and clears the sum, the overflow flag and all handshake state.
// A waiting result stalls the back end at the next run's closing request.
`default_nettype none
module sph_density_accumulator
  import sphd_pkg::*;
#(
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int unsigned COORD_INT_BITS  = COORD_INT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic      full,
  input  wire logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_query_x,
  input  wire logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_query_y,
  input  wire logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_neighbor_x,
  input  wire logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] in_neighbor_y,
  input  wire logic in_neighbor_present,
  input  wire logic in_last,
  output logic      empty,
  input  wire logic pop,
  output logic [DENS_W-1:0] out_density,
  output logic      out_saturated,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned COORD_W = COORD_INT_BITS + COORD_FRAC_BITS;

  logic [COORD_W-1:0] radius_r;
  logic [INV_W-1:0]   inv_r;
  logic               wr;
  logic               q_valid, q_take, q_inside, q_last;
  logic [2*COORD_W:0] q_d2;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= COORD_W'(4096);
      inv_r    <= INV_W'(854400000);
    end else if (wr) begin
      if (paddr[3] == 1'(REG_RADIUS) && paddr[2:0] == 3'd0) radius_r <= pwdata[COORD_W-1:0];
      if (paddr[3] == 1'(REG_INV_VOLUME) && paddr[2:0] == 3'd0) inv_r <= pwdata[INV_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3] == 1'(REG_RADIUS)) prdata = 64'(radius_r);
    else prdata = 64'(inv_r);
  end

  sphd_front #(.COORD_W(COORD_W)) u_front (
    .clk, .rst_n, .push, .full,
    .query_x(in_query_x), .query_y(in_query_y),
    .neighbor_x(in_neighbor_x), .neighbor_y(in_neighbor_y),
    .neighbor_present(in_neighbor_present), .last(in_last),
    .radius(radius_r),
    .q_valid, .q_take, .q_d2, .q_inside, .q_last
  );

  sphd_back #(.COORD_W(COORD_W), .FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_d2, .q_inside, .q_last,
    .radius(radius_r), .inv_volume(inv_r),
    .empty, .pop, .density(out_density), .saturated(out_saturated)
  );

  a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid) else $error("queue read while empty");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_density))) else $error("result lost");

endmodule
`default_nettype wire

// ----- tb/sv/sph_density_accumulator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sph_density_accumulator_test
// Drives runs of neighbor requests into the density accumulator, predicts
// each run's density and saturation flag, and checks every emitted result.
// ----------------------------------------------------------------------------
module sph_density_accumulator_test;
  import sphd_pkg::*;

  localparam int CW = COORD_FRAC_BITS_DEF + COORD_INT_BITS_DEF;
  localparam logic [CW-1:0] CMAX = '1;
  localparam logic [INV_W-1:0] INV_MAX = '1;
  localparam int SETTLE = 60;
  localparam int LIMIT = 1000000;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic saturated;
  } density_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic push, full, empty, pop;
  logic [CW-1:0] in_query_x, in_query_y, in_neighbor_x, in_neighbor_y;
  logic in_neighbor_present, in_last;
  logic [DENS_W-1:0] out_density;
  logic out_saturated;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [63:0] pwdata, prdata;

  density_result_t pending_sums[$];
  logic [CW-1:0] radius_m;
  logic [INV_W-1:0] inv_volume_m;
  logic [DENS_W-1:0] sum_m;
  logic overflow_m;
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  int pop_gap = 0;
  bit idle_on = 1'b1;

  sph_density_accumulator uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_query_x(in_query_x), .in_query_y(in_query_y),
    .in_neighbor_x(in_neighbor_x), .in_neighbor_y(in_neighbor_y),
    .in_neighbor_present(in_neighbor_present), .in_last(in_last),
    .empty(empty), .pop(pop), .out_density(out_density),
    .out_saturated(out_saturated), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  // Updates the running sum for one accepted request and queues the result
  // when the request closes its run.
  task automatic accumulate_density(logic [CW-1:0] qx, logic [CW-1:0] qy,
                                    logic [CW-1:0] nx, logic [CW-1:0] ny,
                                    logic present, logic lst);
    logic [63:0] dx, dy, d2, r2;
    logic [31:0] diff;
    logic [127:0] prod;
    logic [32:0] s;
    logic [DENS_W-1:0] term;
    logic sat;
    density_result_t res;
    if (present) begin
      dx = (qx >= nx) ? 64'(qx - nx) : 64'(nx - qx);
      dy = (qy >= ny) ? 64'(qy - ny) : 64'(ny - qy);
      d2 = dx * dx + dy * dy;
      r2 = 64'(radius_m) * 64'(radius_m);
      if (d2 < r2) begin
        diff = 32'(radius_m) - root_floor(d2);
        prod = 128'(diff) * 128'(diff) * 128'(diff) * 128'(inv_volume_m);
        prod = prod >> (3 * COORD_FRAC_BITS_DEF + 24);
        sat = (prod[127:32] != 0);
        term = sat ? DENS_MAX : prod[31:0];
        s = {1'b0, sum_m} + {1'b0, term};
        if (s[32]) begin
          s = {1'b0, DENS_MAX};
          sat = 1'b1;
        end
        sum_m = s[31:0];
        if (sat) overflow_m = 1'b1;
      end
    end
    if (lst) begin
      res.density = sum_m;
      res.saturated = overflow_m;
      pending_sums.push_back(res);
      sum_m = 0;
      overflow_m = 1'b0;
    end
  endtask

  task automatic send_request(logic [CW-1:0] qx, logic [CW-1:0] qy,
                              logic [CW-1:0] nx, logic [CW-1:0] ny,
                              logic present, logic lst);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    in_query_x <= qx;
    in_query_y <= qy;
    in_neighbor_x <= nx;
    in_neighbor_y <= ny;
    in_neighbor_present <= present;
    in_last <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    accumulate_density(qx, qy, nx, ny, present, lst);
  endtask

  task automatic stop_requests;
    push <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every result, then lets requests that cause none finish.
  task automatic wait_idle;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(int unsigned idx, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx * 8);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_RADIUS) radius_m = value[CW-1:0];
    else if (idx == REG_INV_VOLUME) inv_volume_m = value[INV_W-1:0];
  endtask

  task automatic configure(logic [CW-1:0] radius, logic [INV_W-1:0] inv);
    stop_requests();
    wait_idle();
    write_reg(REG_RADIUS, 64'(radius));
    write_reg(REG_INV_VOLUME, 64'(inv));
  endtask

  function automatic logic [CW-1:0] near_coord(logic [CW-1:0] c);
    longint v;
    longint span;
    span = (radius_m > 2000) ? 2000 : longint'(radius_m);
    v = longint'(c) + longint'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > longint'(CMAX)) v = CMAX;
    return v[CW-1:0];
  endfunction

  // One run of neighbors around a query point; rarely the query moves mid run.
  task automatic send_run(int len);
    logic [CW-1:0] qx, qy, nx, ny;
    logic present;
    qx = CW'($urandom_range(0, CMAX));
    qy = CW'($urandom_range(0, CMAX));
    for (int i = 0; i < len; i++) begin
      present = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 3) == 0) begin
        nx = CW'($urandom_range(0, CMAX));
        ny = CW'($urandom_range(0, CMAX));
      end else begin
        nx = near_coord(qx);
        ny = near_coord(qy);
      end
      if ($urandom_range(0, 30) == 0) qx = CW'($urandom_range(0, CMAX));
      send_request(qx, qy, nx, ny, present, i == len - 1);
    end
  endtask

  task automatic test_directed;
    send_request(100, 100, 100, 100, 1, 1);
    send_request(0, 0, 0, 0, 1, 0);
    send_request(0, 0, 4096, 0, 1, 0);
    send_request(0, 0, 4095, 0, 1, 0);
    send_request(0, 0, 0, 0, 0, 1);
    send_request(CMAX, CMAX, CMAX, CMAX, 1, 0);
    send_request(CMAX, CMAX, CMAX - 1000, CMAX - 2000, 1, 0);
    send_request(CMAX, 0, 0, CMAX, 1, 1);
    send_request(0, 0, 0, 0, 0, 1);
    send_request(5000, 5000, 5100, 4900, 1, 0);
    send_request(9000, 9000, 9100, 8900, 1, 0);
    send_request(CMAX, 0, 0, 0, 0, 0);
    send_request(9000, 9000, 9000, 9000, 1, 1);
    send_request(300, 300, 3000, 300, 1, 0);
    send_request(300, 300, 300, 3000, 1, 1);
  endtask

  task automatic test_register_extremes;
    configure(CMAX, INV_MAX);
    send_request(0, 0, 0, 0, 1, 0);
    send_request(1000, 1000, 1000, 1000, 1, 1);
    send_request(2, 2, 0, 0, 1, 1);
    configure(1, 0);
    send_request(7, 7, 7, 7, 1, 1);
    configure(1, INV_MAX);
    send_request(7, 7, 7, 7, 1, 0);
    send_request(7, 7, 8, 7, 1, 1);
    // A zero radius admits no neighbor at all.
    configure(0, INV_MAX);
    send_request(7, 7, 7, 7, 1, 1);
    configure(4096, 48'd854400000);
  endtask

  task automatic test_random(int total);
    int sent;
    int len;
    sent = 0;
    while (sent < total) begin
      if (sent % 300 == 0 && sent != 0) begin
        case ($urandom_range(0, 3))
          0: configure(4096, 48'd854400000);
          1: configure(CW'($urandom_range(16, 20000)), INV_W'({$urandom, $urandom} >> 40));
          2: configure(CMAX, INV_W'({$urandom, $urandom}));
          default: configure(CW'($urandom_range(1, CMAX)), INV_W'({$urandom, $urandom}));
        endcase
      end
      if (sent > total * 4 / 5) idle_on = 1'b0;
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      send_run(len);
      sent += len;
    end
  endtask

  // The receiver stalls for a long stretch while runs keep arriving.
  task automatic test_backpressure;
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_run($urandom_range(1, 2));
  endtask

  task automatic test_sender_pause;
    send_run(6);
    stop_requests();
    wait_idle();
    send_run(6);
  endtask

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_sums.size() == 0) begin
        $error("result with no request outstanding: density %0h", out_density);
        errors++;
      end else begin
        if (out_density !== pending_sums[0].density) begin
          $error("density: expected %0h, actual %0h",
                 pending_sums[0].density, out_density);
          errors++;
        end
        if (out_saturated !== pending_sums[0].saturated) begin
          $error("saturated: expected %0b, actual %0b",
                 pending_sums[0].saturated, out_saturated);
          errors++;
        end
        void'(pending_sums.pop_front());
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      pop_gap = $urandom_range(0, 5);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    push <= 1'b0;
    pop <= 1'b0;
    in_query_x <= '0;
    in_query_y <= '0;
    in_neighbor_x <= '0;
    in_neighbor_y <= '0;
    in_neighbor_present <= 1'b0;
    in_last <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    radius_m = 4096;
    inv_volume_m = 854400000;
    sum_m = 0;
    overflow_m = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_sender_pause();
    test_random(1850);
    stop_requests();
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
